/* hw/rtl/gf2m_pkg.sv */
// ----------------------------------------------------------------------------
// gf2m_pkg
// Shared types and constants for the GF(2^m) arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gf2m_pkg;

   // operation codes carried on req_mode
   typedef enum logic [1:0] {
      MODE_ADD = 2'd0,
      MODE_SUB = 2'd1,
      MODE_MUL = 2'd2,
      MODE_DIV = 2'd3
   } mode_type;

   // configuration register map
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIELD_DEGREE     = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIELD_POLYNOMIAL = 1'd1;

   // register and field widths
   localparam int DEGREE_W = 4;
   localparam int POLY_W   = 8;
   localparam int ELEM_W   = 8;

   localparam logic [DEGREE_W-1:0] DEGREE_RESET = 4'd2;
   localparam logic [POLY_W-1:0]   POLY_RESET   = 8'd3;
   localparam logic [DEGREE_W-1:0] DEGREE_MIN   = 4'd2;

endpackage

`default_nettype wire

/* hw/rtl/gf2m_arithmetic_unit_core.sv */
// ----------------------------------------------------------------------------
// gf2m_arithmetic_unit_core
// Pipelined GF(2^m) add / subtract / multiply / divide, one item per cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_*): mode and two operands, transferred when
//    req_valid is high and req_stall is low.
//  - Response channel (rsp_*): result and divide-by-zero flag, transferred
//    when rsp_valid is high and rsp_stall is low.
//  - CSR port (csr_*): write-only. Index 0 is the field degree m (clamped
//    to 2..MAX_DEGREE), index 1 the low m bits of the reduction polynomial.
//    Write only while no transfers are in flight.
//  - Every mode passes through the same stages: one input stage,
//    MAX_DEGREE exponentiation stages (each squares and, while the stage
//    number is 2..m, multiplies into the running inverse), one final
//    multiply / output stage. Throughput is one transfer per cycle while rsp_stall is low.
//  - Divide computes a * b^(2^m-2); b == 0 gives result 0 and the flag.
//  - Reset empties the pipeline and loads m = 2, polynomial x^2+x+1.
//  - When the receiver stalls, items keep advancing into empty stages;
//    req_stall rises only once every stage holds an item.
// ----------------------------------------------------------------------------
`default_nettype none

module gf2m_arithmetic_unit_core #(
   parameter int MAX_DEGREE = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,

   input  wire logic                              csr_write_enable,
   input  wire logic [gf2m_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [gf2m_pkg::CSR_DATA_W-1:0]   csr_wdata,

   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [1:0]                        req_mode,
   input  wire logic [gf2m_pkg::ELEM_W-1:0]       req_operand_a,
   input  wire logic [gf2m_pkg::ELEM_W-1:0]       req_operand_b,

   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [gf2m_pkg::ELEM_W-1:0]            rsp_result,
   output logic                                   rsp_divide_by_zero
);

   import gf2m_pkg::*;

   localparam int W  = MAX_DEGREE;           // internal element width
   localparam int MW = $clog2(MAX_DEGREE + 1);
   localparam int N  = MAX_DEGREE;           // exponentiation stages

   // carry-less multiply, reduced by poly; top is the one-hot x^(m-1) bit
   function automatic logic [W-1:0] gf_mul(input logic [W-1:0] x,
                                           input logic [W-1:0] y,
                                           input logic [W-1:0] mask,
                                           input logic [W-1:0] top,
                                           input logic [W-1:0] poly);
      logic [W-1:0] p;
      p = '0;
      for (int i = W - 1; i >= 0; i--) begin
         p = ((p << 1) & mask) ^ ((|(p & top)) ? poly : '0);
         if (y[i]) begin
            p = p ^ x;
         end
      end
      return p;
   endfunction

   // ---------------------------------------------------------------- CSRs
   logic [DEGREE_W-1:0] degree_ff, degree_in;
   logic [POLY_W-1:0]   poly_ff, poly_in;

   always_comb begin
      degree_in = degree_ff;
      poly_in   = poly_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_FIELD_DEGREE:     degree_in = csr_wdata[DEGREE_W-1:0];
            CSR_FIELD_POLYNOMIAL: poly_in   = csr_wdata[POLY_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= DEGREE_RESET;
         poly_ff   <= POLY_RESET;
      end else begin
         degree_ff <= degree_in;
         poly_ff   <= poly_in;
      end
   end

   // effective degree, derived masks; user keeps them static with items in flight; unenforced
   logic [MW-1:0]       m_eff;
   logic [W-1:0]        elem_mask;
   logic [W-1:0]        top_bit;
   logic [W-1:0]        poly_w;
   logic [W+POLY_W-1:0] poly_ext;

   always_comb begin
      if (degree_ff < DEGREE_MIN) begin
         m_eff = MW'(2);
      end else if (int'(degree_ff) > MAX_DEGREE) begin
         m_eff = MW'(MAX_DEGREE);
      end else begin
         m_eff = MW'(degree_ff);
      end
      for (int i = 0; i < W; i++) begin
         elem_mask[i] = (i < int'(m_eff));
         top_bit[i]   = (i == int'(m_eff) - 1);
      end
      poly_ext = {{W{1'b0}}, poly_ff};
      poly_w   = poly_ext[W-1:0] & elem_mask;
   end

   // ------------------------------------------------------------ pipeline
   // stage 0 holds masked operands; stage j holds b^(2^j) and the partial
   // inverse (product of b^(2^i) for i = 1 .. min(j-1, m-1))
   logic [N:0]   valid_ff;
   logic [N+1:0] ready;
   logic         out_ready;

   mode_type     mode_ff [0:N];
   mode_type     mode_in [0:N];
   logic [W-1:0] a_ff    [0:N];
   logic [W-1:0] a_in    [0:N];
   logic [W-1:0] b_ff    [0:N];
   logic [W-1:0] b_in    [0:N];
   logic [W-1:0] sq_ff   [0:N];
   logic [W-1:0] sq_in   [0:N];
   logic [W-1:0] inv_ff  [0:N];
   logic [W-1:0] inv_in  [0:N];

   // a stage takes new data when it is empty or its holder moves on
   assign out_ready  = !rsp_valid || !rsp_stall;
   assign ready[N+1] = out_ready;
   assign req_stall  = !ready[0];

   genvar k;
   generate
      for (k = 0; k <= N; k++) begin : g_ready
         assign ready[k] = !valid_ff[k] || ready[k+1];
      end
   endgenerate

   // input stage
   logic [W+ELEM_W-1:0] a_ext;
   logic [W+ELEM_W-1:0] b_ext;

   always_comb begin
      a_ext      = {{W{1'b0}}, req_operand_a};
      b_ext      = {{W{1'b0}}, req_operand_b};
      mode_in[0] = mode_type'(req_mode);
      a_in[0]    = a_ext[W-1:0] & elem_mask;
      b_in[0]    = b_ext[W-1:0] & elem_mask;
      sq_in[0]   = b_ext[W-1:0] & elem_mask;
      inv_in[0]  = W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (ready[0]) begin
         valid_ff[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0] && req_valid) begin
         mode_ff[0] <= mode_in[0];
         a_ff[0]    <= a_in[0];
         b_ff[0]    <= b_in[0];
         sq_ff[0]   <= sq_in[0];
         inv_ff[0]  <= inv_in[0];
      end
   end

   // exponentiation stages
   generate
      for (k = 1; k <= N; k++) begin : g_stage
         always_comb begin
            mode_in[k] = mode_ff[k-1];
            a_in[k]    = a_ff[k-1];
            b_in[k]    = b_ff[k-1];
            sq_in[k]   = gf_mul(sq_ff[k-1], sq_ff[k-1], elem_mask, top_bit, poly_w);
            if ((k >= 2) && (k <= int'(m_eff))) begin
               inv_in[k] = gf_mul(inv_ff[k-1], sq_ff[k-1], elem_mask, top_bit, poly_w);
            end else begin
               inv_in[k] = inv_ff[k-1];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (ready[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end

         always_ff @(posedge clock) begin
            if (ready[k] && valid_ff[k-1]) begin
               mode_ff[k] <= mode_in[k];
               a_ff[k]    <= a_in[k];
               b_ff[k]    <= b_in[k];
               sq_ff[k]   <= sq_in[k];
               inv_ff[k]  <= inv_in[k];
            end
         end
      end
   endgenerate

   // --------------------------------------------------------- output stage
   logic                rsp_valid_ff;
   logic [ELEM_W-1:0]   result_ff, result_in;
   logic                dz_ff, dz_in;
   logic [W-1:0]        mul_operand;
   logic [W-1:0]        res_w;
   logic [W+ELEM_W-1:0] res_ext;

   always_comb begin
      dz_in       = 1'b0;
      mul_operand = (mode_ff[N] == MODE_DIV) ? inv_ff[N] : b_ff[N];
      case (mode_ff[N])
         MODE_ADD, MODE_SUB: res_w = a_ff[N] ^ b_ff[N];
         MODE_MUL:           res_w = gf_mul(a_ff[N], mul_operand, elem_mask,
                                            top_bit, poly_w);
         MODE_DIV: begin
            if (b_ff[N] == '0) begin
               dz_in = 1'b1;
               res_w = '0;
            end else begin
               res_w = gf_mul(a_ff[N], mul_operand, elem_mask, top_bit, poly_w);
            end
         end
         default:            res_w = '0;
      endcase
      res_ext   = {{ELEM_W{1'b0}}, res_w};
      result_in = res_ext[ELEM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= valid_ff[N];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && valid_ff[N]) begin
         result_ff <= result_in;
         dz_ff     <= dz_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result         = result_ff;
   assign rsp_divide_by_zero = dz_ff;

`ifndef SYNTHESIS
   // a flagged divide always returns the zero element
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && dz_ff |-> result_ff == '0)
      else $error("divide_by_zero with nonzero result");

   // input back-pressure only when every stage and the output are occupied
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff) && rsp_valid_ff && rsp_stall)
      else $error("req_stall with a free pipeline slot");

   // reset empties the whole pipeline
   assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && (valid_ff == '0))
      else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire
